>>> design/ordered_dither_gray_to_2bit_macros.svh
// Assertion macros for the ordered dither quantizer checks.
`ifndef ORDERED_DITHER_GRAY_TO_2BIT_MACROS_SVH
`define ORDERED_DITHER_GRAY_TO_2BIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ODG2_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odg2 check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define ODG2_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odg2 check failed");

`endif

>>> design/odg2_pkg.sv
// Types, codes and the threshold compare shared by the ordered dither quantizer.
`timescale 1ns / 1ps
`default_nettype none

package odg2_pkg;

    localparam int PIXELS_PER_BYTE = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int SIZE_REG_W      = 5;

    // input word kinds
    localparam logic ACT_PIXEL      = 1'b0;
    localparam logic ACT_MASK_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH  = 1'd1;

    typedef struct packed {
        logic       action;
        logic [7:0] gray;
        logic       frame_start;
        logic       row_end;
        logic [3:0] entry_row;
        logic [3:0] entry_col;
        logic [7:0] thr_low;
        logic [7:0] thr_mid;
        logic [7:0] thr_high;
    } t_in_word;

    typedef struct packed {
        logic [7:0] packed_res;
        logic       last_of_row;
    } t_out_word;

    typedef struct packed {
        logic [7:0] thr_high;
        logic [7:0] thr_mid;
        logic [7:0] thr_low;
    } t_entry;

    typedef struct packed {
        logic [7:0] gray;
        logic       frame_start;
        logic       row_end;
    } t_pix_ctl;

    // the thr_high compare has priority, then thr_mid, then thr_low, whatever the ordering of the three values
    function automatic logic [1:0] quantize(input logic [7:0] g, input t_entry e);
        logic [1:0] lvl;
        if (g > e.thr_high) begin
            lvl = 2'd3;
        end else if (g > e.thr_mid) begin
            lvl = 2'd2;
        end else if (g > e.thr_low) begin
            lvl = 2'd1;
        end else begin
            lvl = 2'd0;
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

>>> design/odg2_pack.sv
// Level compare, four-to-a-byte packing and the output register.
`timescale 1ns / 1ps
`default_nettype none

module odg2_pack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire odg2_pkg::t_pix_ctl  i_ctl,
    input  wire odg2_pkg::t_entry    i_entry,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output odg2_pkg::t_out_word      o_out_data
);

    logic [1:0] r_slot;
    logic [5:0] r_pend;
    logic       r_out_valid;
    odg2_pkg::t_out_word r_out_data;

    logic [1:0] slot_eff;
    logic [5:0] pend_eff;
    logic [1:0] lvl;
    logic [7:0] acc;
    logic       emit;
    logic       fire;
    logic [2:0] shamt;

    always_comb begin
        // frame start drops any half-filled byte
        slot_eff = i_ctl.frame_start ? 2'd0 : r_slot;
        pend_eff = i_ctl.frame_start ? 6'd0 : r_pend;
        lvl      = odg2_pkg::quantize(i_ctl.gray, i_entry);
        acc      = {pend_eff, lvl};
        emit     = (slot_eff == 2'(odg2_pkg::PIXELS_PER_BYTE - 1)) || i_ctl.row_end;
        shamt    = {~slot_eff, 1'b0};
    end

    assign o_ready = !r_out_valid || !i_out_stall;
    assign fire    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 2'd0;
            r_pend <= 6'd0;
        end else if (fire) begin
            if (emit) begin
                r_slot <= 2'd0;
                r_pend <= 6'd0;
            end else begin
                r_slot <= slot_eff + 2'd1;
                r_pend <= acc[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_data.packed_res  <= acc << shamt;
            r_out_data.last_of_row <= i_ctl.row_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> design/ordered_dither_gray_to_2bit.sv
// Top level of the ordered dither quantizer: mask memory, tile phases, pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Ordered dither quantizer, 8-bit gray to 2-bit levels packed four per byte.
// Takes one input word per clock, pixel or mask write alike, as long as the
// output side keeps up. A pixel reads its threshold entry from the mask memory
// at the edge it is accepted, held in r_entry beside the stage-1 registers;
// the pack stage then compares and packs the levels, and a finished byte is
// registered into the output register. The single memory read port per pixel
// sets the rate of one pixel per clock while the output is not stalled. The
// mask memory holds MASK_SIDE_MAX^2 entries and is not cleared after reset:
// load every entry the configured mask size can reach before streaming
// pixels. Change mask_height or mask_width only while the block is idle.
module ordered_dither_gray_to_2bit #(
    parameter int MASK_SIDE_MAX = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire odg2_pkg::t_in_word                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output odg2_pkg::t_out_word                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [odg2_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [odg2_pkg::SIZE_REG_W-1:0]     i_cfg_data
);

    localparam int SW    = (MASK_SIDE_MAX > 1) ? $clog2(MASK_SIDE_MAX) : 1;
    localparam int DEPTH = MASK_SIDE_MAX * MASK_SIDE_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = ($clog2(MASK_SIDE_MAX + 1) > odg2_pkg::SIZE_REG_W)
                           ? $clog2(MASK_SIDE_MAX + 1) : odg2_pkg::SIZE_REG_W;
    localparam logic [EW-1:0] SIDE_MAX_E = EW'(MASK_SIDE_MAX);

    odg2_pkg::t_entry mem [DEPTH];
    odg2_pkg::t_entry r_entry;

    logic [odg2_pkg::SIZE_REG_W-1:0] r_mask_height;
    logic [odg2_pkg::SIZE_REG_W-1:0] r_mask_width;
    logic [SW-1:0] r_row_ph;
    logic [SW-1:0] r_col_ph;
    logic          r_s1_valid;
    odg2_pkg::t_pix_ctl r_s1_ctl;

    logic          pk_ready;
    logic          accept;
    logic          pix_acc;
    logic          wr_acc;
    logic          wr_in_range;
    logic [EW-1:0] hgt;
    logic [EW-1:0] wid;
    logic [SW-1:0] rph_eff;
    logic [SW-1:0] cph_eff;
    logic [SW-1:0] r_sel;
    logic [SW-1:0] c_sel;
    logic [EW-1:0] row_inc;
    logic [EW-1:0] col_inc;
    logic [SW-1:0] n_row_ph;
    logic [SW-1:0] n_col_ph;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign o_in_stall = r_s1_valid && !pk_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign pix_acc    = accept && (i_in_data.action == odg2_pkg::ACT_PIXEL);
    assign wr_acc     = accept && (i_in_data.action == odg2_pkg::ACT_MASK_WRITE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_height <= odg2_pkg::SIZE_REG_W'(1);
            r_mask_width  <= odg2_pkg::SIZE_REG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                odg2_pkg::CFG_MASK_HEIGHT: r_mask_height <= i_cfg_data;
                odg2_pkg::CFG_MASK_WIDTH:  r_mask_width  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective mask size: 0 acts as 1, clamp at MASK_SIDE_MAX
    always_comb begin
        hgt = EW'(r_mask_height);
        wid = EW'(r_mask_width);
        if (hgt == '0) begin
            hgt = EW'(1);
        end else if (hgt > SIDE_MAX_E) begin
            hgt = SIDE_MAX_E;
        end
        if (wid == '0) begin
            wid = EW'(1);
        end else if (wid > SIDE_MAX_E) begin
            wid = SIDE_MAX_E;
        end
    end

    always_comb begin
        rph_eff = i_in_data.frame_start ? '0 : r_row_ph;
        cph_eff = i_in_data.frame_start ? '0 : r_col_ph;
        // a phase left beyond a shrunk mask looks up phase 0
        r_sel   = (EW'(rph_eff) < hgt) ? rph_eff : '0;
        c_sel   = (EW'(cph_eff) < wid) ? cph_eff : '0;
        rd_addr = AW'(32'(r_sel) * MASK_SIDE_MAX + 32'(c_sel));
        row_inc = EW'(rph_eff) + EW'(1);
        col_inc = EW'(cph_eff) + EW'(1);
        if (i_in_data.row_end) begin
            n_col_ph = '0;
            n_row_ph = (row_inc >= hgt) ? '0 : SW'(row_inc);
        end else begin
            n_col_ph = (col_inc >= wid) ? '0 : SW'(col_inc);
            n_row_ph = rph_eff;
        end
        wr_in_range = (32'(i_in_data.entry_row) < MASK_SIDE_MAX)
                   && (32'(i_in_data.entry_col) < MASK_SIDE_MAX);
        wr_addr = AW'(32'(i_in_data.entry_row) * MASK_SIDE_MAX
                      + 32'(i_in_data.entry_col));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ph <= '0;
            r_col_ph <= '0;
        end else if (pix_acc) begin
            r_row_ph <= n_row_ph;
            r_col_ph <= n_col_ph;
        end
    end

    // mask memory: one write or one read per cycle, never both
    always_ff @(posedge i_clk) begin
        if (wr_acc && wr_in_range) begin
            mem[wr_addr] <= '{thr_high: i_in_data.thr_high,
                              thr_mid:  i_in_data.thr_mid,
                              thr_low:  i_in_data.thr_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_entry <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (pk_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_ctl <= '{gray:        i_in_data.gray,
                          frame_start: i_in_data.frame_start,
                          row_end:     i_in_data.row_end};
        end
    end

    odg2_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_ctl       (r_s1_ctl),
        .i_entry     (r_entry),
        .o_ready     (pk_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> design/odg2_chk.sv
// Port-level checks for the ordered dither quantizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_dither_gray_to_2bit_macros.svh"

module odg2_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire odg2_pkg::t_in_word  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire odg2_pkg::t_out_word o_out_data
);

    logic row_end_pix;

    assign row_end_pix = i_in_valid && !o_in_stall
                      && (i_in_data.action == odg2_pkg::ACT_PIXEL)
                      && i_in_data.row_end;

    `ODG2_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `ODG2_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))
    // with the output register empty the pipeline always has room
    `ODG2_ASSERT_IMPL(a_no_idle_stall, !o_out_valid, !o_in_stall)
    // a row end into an empty output side shows a word once through the stage-1 and output registers
    `ODG2_ASSERT_IMPL(a_row_end_out, row_end_pix && !o_out_valid, ##2 o_out_valid)

endmodule

bind ordered_dither_gray_to_2bit odg2_chk u_odg2_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
